// File: src/spmq_pkg.sv
// Package for the strict priority multi-queue: default sizes, field widths,
// operation and status codes, and the sequencer state type.
// Used by strict_priority_multi_queue; no dependencies.
package spmq_pkg;

  localparam int LEVELS_DEF = 4;
  localparam int DEPTH_DEF  = 16;

  localparam int VALUE_W  = 32;
  localparam int LEVEL_W  = 3;
  localparam int STATUS_W = 2;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 72;

  localparam logic ACT_ENQ = 1'b0;
  localparam logic ACT_DEQ = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STAT_DONE      = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_BAD_LEVEL = 2'd2,
    STAT_DEQ_EMPTY = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_LOAD
  } state_t;

endpackage

// File: src/spmq_ram.sv
// Generic single-clock RAM: one write port, two read ports, registered reads.
// No dependencies.
module spmq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// File: src/strict_priority_multi_queue.sv
// Strict priority multi-queue: one ring FIFO of DEPTH words per level, all
// rings held in one RAM (spmq_ram), pointers and counts in registers.
// Depends on spmq_pkg and spmq_ram.
//
// Input transaction: tuser = action (enqueue or dequeue), tdata = value and
// level. Enqueue appends to the ring of that level; dequeue pops the oldest
// entry of the highest non-empty level. Every input gives one result:
// tuser = status, tdata = front value, rear value and all-empty flag.
// Each input passes through pointer update and RAM write, then the RAM
// read of front and rear entries, then the output register load; the
// block takes no new input until the last one has reached the load.
// A result waiting in the output register does not block the next input;
// a stalled receiver holds the load step until the register frees.
// Reset clears all pointers and counts, so every level starts empty; the
// RAM needs no clearing since only occupied entries are read.
module strict_priority_multi_queue #(
  parameter int LEVELS = spmq_pkg::LEVELS_DEF,
  parameter int DEPTH  = spmq_pkg::DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [spmq_pkg::IN_TDATA_W-1:0] in_tdata,  // value[31:0], level[34:32]
  input  logic                            in_tuser,  // action
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [spmq_pkg::OUT_TDATA_W-1:0] out_tdata, // front[31:0], rear[63:32], all_empty[64]
  output logic [spmq_pkg::STATUS_W-1:0]   out_tuser  // status
);

  import spmq_pkg::*;

  localparam int LVL_W    = $clog2(LEVELS);
  localparam int IDX_W    = $clog2(DEPTH);
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int RAM_D    = LEVELS * (2 ** IDX_W);
  localparam int ADDR_W   = $clog2(RAM_D);

  state_t state_r, state_nxt;

  logic [IDX_W-1:0] head_r  [LEVELS];
  logic [IDX_W-1:0] head_nxt[LEVELS];
  logic [IDX_W-1:0] tail_r  [LEVELS];
  logic [IDX_W-1:0] tail_nxt[LEVELS];
  logic [CNT_W-1:0] count_r  [LEVELS];
  logic [CNT_W-1:0] count_nxt[LEVELS];

  status_t status_r, status_nxt;

  logic                out_valid_r, out_valid_nxt;
  status_t             out_status_r;
  logic [VALUE_W-1:0]  out_front_r, out_rear_r;
  logic                out_empty_r;

  logic                accept;
  logic                load;
  logic [VALUE_W-1:0]  in_value;
  logic [LEVEL_W-1:0]  in_level;
  logic [LVL_W-1:0]    lvl_idx;
  logic [LVL_W-1:0]    front_lvl, rear_lvl;
  logic                any_full;
  logic [IDX_W-1:0]    rear_slot;

  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr, ram_raddr_a, ram_raddr_b;
  logic [VALUE_W-1:0]  ram_rdata_a, ram_rdata_b;

  assign in_value = in_tdata[VALUE_W-1:0];
  assign in_level = in_tdata[VALUE_W+LEVEL_W-1:VALUE_W];
  assign lvl_idx  = LVL_W'(in_level);
  assign accept   = in_tvalid && in_tready;

  always_comb begin
    front_lvl = '0;
    rear_lvl  = '0;
    any_full  = 1'b0;
    for (int lv = 0; lv < LEVELS; lv++) begin
      if (count_r[lv] != '0) begin
        front_lvl = LVL_W'(lv);
        any_full  = 1'b1;
      end
    end
    for (int lv = LEVELS - 1; lv >= 0; lv--) begin
      if (count_r[lv] != '0) begin
        rear_lvl = LVL_W'(lv);
      end
    end
  end

  assign rear_slot = (tail_r[rear_lvl] == '0) ? IDX_W'(DEPTH - 1)
                                              : tail_r[rear_lvl] - 1'b1;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: state_nxt = ST_LOAD;
      ST_LOAD: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    load      = 1'b0;
    unique case (state_r)
      ST_IDLE: in_tready = 1'b1;
      ST_READ: ;
      ST_LOAD: load = !out_valid_r || out_tready;
      default: ;
    endcase
  end

  always_comb begin
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    count_nxt  = count_r;
    status_nxt = status_r;
    ram_we     = 1'b0;
    ram_waddr  = {lvl_idx, tail_r[lvl_idx]};
    if (accept) begin
      status_nxt = STAT_DONE;
      if (in_tuser == ACT_ENQ) begin
        if (32'(in_level) >= LEVELS) begin
          status_nxt = STAT_BAD_LEVEL;
        end else if (count_r[lvl_idx] == CNT_W'(DEPTH)) begin
          status_nxt = STAT_FULL;
        end else begin
          ram_we             = 1'b1;
          tail_nxt[lvl_idx]  = (tail_r[lvl_idx] == IDX_W'(DEPTH - 1)) ? '0
                                                                      : tail_r[lvl_idx] + 1'b1;
          count_nxt[lvl_idx] = count_r[lvl_idx] + 1'b1;
        end
      end else if (!any_full) begin
        status_nxt = STAT_DEQ_EMPTY;
      end else begin
        head_nxt[front_lvl]  = (head_r[front_lvl] == IDX_W'(DEPTH - 1)) ? '0
                                                                        : head_r[front_lvl] + 1'b1;
        count_nxt[front_lvl] = count_r[front_lvl] - 1'b1;
      end
    end
  end

  assign ram_raddr_a = {front_lvl, head_r[front_lvl]};
  assign ram_raddr_b = {rear_lvl, rear_slot};

  spmq_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (RAM_D)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (in_value),
    .raddr_a (ram_raddr_a),
    .rdata_a (ram_rdata_a),
    .raddr_b (ram_raddr_b),
    .rdata_b (ram_rdata_b)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      status_r    <= STAT_DONE;
      for (int lv = 0; lv < LEVELS; lv++) begin
        head_r[lv]  <= '0;
        tail_r[lv]  <= '0;
        count_r[lv] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      status_r    <= status_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_status_r <= status_r;
      out_empty_r  <= !any_full;
      out_front_r  <= any_full ? ram_rdata_a : '0;
      out_rear_r   <= any_full ? ram_rdata_b : '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {{(OUT_TDATA_W - 2 * VALUE_W - 1){1'b0}}, out_empty_r,
                       out_rear_r, out_front_r};

`ifndef SYNTHESIS
  a_seq_order: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == ST_READ) ##1 (state_r == ST_LOAD))
    else $error("accepted transaction did not advance to read and load");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[2*VALUE_W]) |-> (out_tdata[2*VALUE_W-1:0] == '0))
    else $error("empty result carries nonzero front or rear");

  a_deq_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == STAT_DEQ_EMPTY) |-> out_tdata[2*VALUE_W])
    else $error("empty dequeue without all_empty flag");

  a_load_slot: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> out_valid_r)
    else $error("result load lost");
`endif

endmodule
